[rtl/lie_pkg.sv]
package lie_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned WIDE_W = 64;
	localparam int unsigned CNT_W  = 5;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [3:0]        node_index;
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic signed [31:0] query_x;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} out_word_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DUP_RD,
		S_DUP_CMP,
		S_HIT_RD,
		S_HIT_CMP,
		S_BAS_INIT,
		S_BAS_RD,
		S_DIV_GO,
		S_DIV,
		S_MUL_GO,
		S_MUL_RUN,
		S_MUL,
		S_TERM_GO,
		S_TERM_RUN,
		S_TERM,
		S_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic ld_pair;
		logic cmp_dup;
		logic cmp_hit;
		logic bas_init;
		logic div_start;
		logic mul_go;
		logic mul_sel;
		logic mul_basis;
		logic mul_term;
		logic acc_add;
		logic clr;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic eq_x;
		logic eq_q;
		logic div_done;
		logic mul_done;
	} dp_stat_t;

endpackage

[rtl/lie_div.sv]
module lie_div #(
	parameter int unsigned NUM_W = 80,
	parameter int unsigned DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int unsigned CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = run_q && (cnt_q == CW'(1));
	assign quo  = quo_q;

endmodule

[rtl/lie_datapath.sv]
module lie_datapath #(
	parameter int unsigned MAX_NODES = 16,
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned IW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ld_we,
	input  logic [IW-1:0]       ld_idx,
	input  logic signed [31:0]  ld_x,
	input  logic signed [31:0]  ld_y,
	input  logic signed [31:0]  query_x,
	input  logic [IW-1:0]       idx_i,
	input  logic [IW-1:0]       idx_j,
	input  lie_pkg::dp_cmd_t    cmd,
	output lie_pkg::dp_stat_t   stat,
	output lie_pkg::out_word_t  res
);
	localparam logic [63:0] CAP = 64'd1 << 61;
	localparam int unsigned NW = 34 + FRAC_BITS;

	logic signed [31:0] xs [MAX_NODES];
	logic signed [31:0] ys [MAX_NODES];
	logic signed [31:0] xi_q, xj_q, yi_q, q_q;
	logic [63:0]        bas_mag_q;
	logic               bas_neg_q, bsat_q, over_q, fneg_q;
	logic signed [63:0] acc_q;
	logic [63:0]        term_mag_q;
	logic               term_neg_q;
	logic [NW-1:0]      quo;
	logic               div_done;
	logic signed [32:0] dnum, dden;
	logic [32:0]        mnum, mden;
	logic [63:0]        fmag;
	logic [127:0]       prod;
	logic [127:0]       psh;
	logic [63:0]        pmag;
	logic               psat;
	logic [63:0]        yim;
	logic signed [64:0] sum;
	logic [63:0]        ma_q, mb_q;
	logic [127:0]       prod_q;
	logic [1:0]         mstep_q;
	logic               mrun_q;
	logic [31:0]        pp_a, pp_b;
	logic [63:0]        pp;
	logic [127:0]       pp_sh;

	always_ff @(posedge clk) begin
		if (ld_we) begin
			xs[ld_idx] <= ld_x;
			ys[ld_idx] <= ld_y;
		end
		if (cmd.ld_pair) begin
			xi_q <= xs[idx_i];
			yi_q <= ys[idx_i];
			xj_q <= xs[idx_j];
		end
	end

	assign dnum = 33'(q_q) - 33'(xj_q);
	assign dden = 33'(xi_q) - 33'(xj_q);
	assign mnum = dnum[32] ? 33'(-dnum) : 33'(dnum);
	assign mden = dden[32] ? 33'(-dden) : 33'(dden);

	lie_div #(.NUM_W(NW), .DEN_W(33)) u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_start),
		.num(NW'({mnum, FRAC_BITS'(0)})), .den(mden),
		.done(div_done), .quo(quo)
	);

	assign fmag = (64'(quo) > CAP) ? CAP : 64'(quo);
	assign yim  = yi_q[31] ? 64'(-65'(yi_q)) : 64'(yi_q);

	always_comb begin
		case (mstep_q)
			2'd0: begin
				pp_a = ma_q[31:0];
				pp_b = mb_q[31:0];
			end
			2'd1: begin
				pp_a = ma_q[31:0];
				pp_b = mb_q[63:32];
			end
			2'd2: begin
				pp_a = ma_q[63:32];
				pp_b = mb_q[31:0];
			end
			default: begin
				pp_a = ma_q[63:32];
				pp_b = mb_q[63:32];
			end
		endcase
	end

	assign pp    = 64'(pp_a) * 64'(pp_b);
	assign pp_sh = (mstep_q == 2'd0) ? 128'(pp)
		: (mstep_q == 2'd3) ? {pp, 64'd0} : {32'd0, pp, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q  <= 1'b0;
			mstep_q <= '0;
		end else if (cmd.mul_go) begin
			mrun_q  <= 1'b1;
			mstep_q <= '0;
		end else if (mrun_q) begin
			mstep_q <= mstep_q + 1'b1;
			if (mstep_q == 2'd3) begin
				mrun_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			ma_q   <= bas_mag_q;
			mb_q   <= cmd.mul_sel ? yim : fmag;
			prod_q <= '0;
		end else if (mrun_q) begin
			prod_q <= prod_q + pp_sh;
		end
	end

	assign prod = prod_q;
	assign psh  = prod >> FRAC_BITS;
	assign psat = (prod[127:64] != 64'd0) || (psh > 128'(CAP));
	assign pmag = psat ? CAP : psh[63:0];
	assign sum  = 65'(acc_q) + (term_neg_q ? -65'(term_mag_q) : 65'(term_mag_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q <= 1'b0;
			acc_q  <= '0;
		end else if (cmd.clr) begin
			over_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (cmd.mul_term) begin
				if (psat || (bsat_q && yi_q != 0)) begin
					over_q <= 1'b1;
				end
			end
			if (cmd.acc_add) begin
				if (sum > 65'sd2305843009213693952) begin
					acc_q  <= 64'sd2305843009213693952;
					over_q <= 1'b1;
				end else if (sum < -65'sd2305843009213693952) begin
					acc_q  <= -64'sd2305843009213693952;
					over_q <= 1'b1;
				end else begin
					acc_q <= sum[63:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			q_q <= query_x;
		end
		if (cmd.div_start) begin
			fneg_q <= dnum[32] ^ dden[32];
		end
		if (cmd.bas_init) begin
			bas_mag_q <= 64'd1 << FRAC_BITS;
			bas_neg_q <= 1'b0;
			bsat_q    <= 1'b0;
		end else if (cmd.mul_basis) begin
			bas_mag_q <= pmag;
			bas_neg_q <= bas_neg_q ^ fneg_q;
			bsat_q    <= bsat_q | psat;
		end
		if (cmd.mul_term) begin
			term_mag_q <= pmag;
			term_neg_q <= (yi_q[31] ^ bas_neg_q) && (pmag != 0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp_dup) begin
			res.value  <= '0;
			res.status <= lie_pkg::ST_DUP;
		end else if (cmd.cmp_hit) begin
			res.value  <= yi_q;
			res.status <= lie_pkg::ST_OK;
		end else if (cmd.finish) begin
			if (over_q || acc_q > 64'sd2147483647 || acc_q < -64'sd2147483648) begin
				res.value  <= acc_q[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
				res.status <= lie_pkg::ST_OVF;
			end else begin
				res.value  <= acc_q[31:0];
				res.status <= lie_pkg::ST_OK;
			end
		end
	end

	assign stat.eq_x     = (xi_q == xj_q);
	assign stat.eq_q     = (xi_q == q_q);
	assign stat.div_done = div_done;
	assign stat.mul_done = mrun_q && (mstep_q == 2'd3);

endmodule

[rtl/lie_ctrl.sv]
module lie_ctrl #(
	parameter int unsigned MAX_NODES = 16,
	parameter int unsigned IW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go_eval,
	input  logic [4:0]        node_count,
	input  lie_pkg::dp_stat_t stat,
	output lie_pkg::dp_cmd_t  cmd,
	output logic [IW-1:0]     idx_i,
	output logic [IW-1:0]     idx_j,
	output logic              busy,
	output logic              done
);
	localparam int unsigned NCW = IW + 1;

	lie_pkg::state_t st_q, st_d;
	logic [NCW-1:0] n_q, i_q, j_q, i_d, j_d;
	logic [NCW-1:0] n_eff;

	assign n_eff = (32'(node_count) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lie_pkg::S_IDLE;
			n_q  <= '0;
			i_q  <= '0;
			j_q  <= '0;
		end else begin
			st_q <= st_d;
			i_q  <= i_d;
			j_q  <= j_d;
			if (go_eval) begin
				n_q <= n_eff;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		i_d  = i_q;
		j_d  = j_q;
		unique case (st_q)
			lie_pkg::S_IDLE: begin
				if (go_eval) begin
					i_d  = '0;
					j_d  = NCW'(1);
					st_d = lie_pkg::S_DUP_RD;
				end
			end
			lie_pkg::S_DUP_RD: begin
				if (i_q + 1'b1 >= n_q) begin
					i_d  = '0;
					st_d = lie_pkg::S_HIT_RD;
				end else if (j_q >= n_q) begin
					i_d  = i_q + 1'b1;
					j_d  = i_q + NCW'(2);
				end else begin
					st_d = lie_pkg::S_DUP_CMP;
				end
			end
			lie_pkg::S_DUP_CMP: begin
				if (stat.eq_x) begin
					st_d = lie_pkg::S_DONE;
				end else begin
					j_d  = j_q + 1'b1;
					st_d = lie_pkg::S_DUP_RD;
				end
			end
			lie_pkg::S_HIT_RD: begin
				if (i_q >= n_q) begin
					i_d  = '0;
					st_d = lie_pkg::S_BAS_INIT;
				end else begin
					st_d = lie_pkg::S_HIT_CMP;
				end
			end
			lie_pkg::S_HIT_CMP: begin
				if (stat.eq_q) begin
					st_d = lie_pkg::S_DONE;
				end else begin
					i_d  = i_q + 1'b1;
					st_d = lie_pkg::S_HIT_RD;
				end
			end
			lie_pkg::S_BAS_INIT: begin
				if (i_q >= n_q) begin
					st_d = lie_pkg::S_DONE;
				end else begin
					j_d  = '0;
					st_d = lie_pkg::S_BAS_RD;
				end
			end
			lie_pkg::S_BAS_RD: begin
				if (j_q >= n_q) begin
					st_d = lie_pkg::S_TERM_GO;
				end else if (j_q == i_q) begin
					j_d = j_q + 1'b1;
				end else begin
					st_d = lie_pkg::S_DIV_GO;
				end
			end
			lie_pkg::S_DIV_GO: begin
				st_d = lie_pkg::S_DIV;
			end
			lie_pkg::S_DIV: begin
				if (stat.div_done) begin
					st_d = lie_pkg::S_MUL_GO;
				end
			end
			lie_pkg::S_MUL_GO: begin
				st_d = lie_pkg::S_MUL_RUN;
			end
			lie_pkg::S_MUL_RUN: begin
				if (stat.mul_done) begin
					st_d = lie_pkg::S_MUL;
				end
			end
			lie_pkg::S_MUL: begin
				j_d  = j_q + 1'b1;
				st_d = lie_pkg::S_BAS_RD;
			end
			lie_pkg::S_TERM_GO: begin
				st_d = lie_pkg::S_TERM_RUN;
			end
			lie_pkg::S_TERM_RUN: begin
				if (stat.mul_done) begin
					st_d = lie_pkg::S_TERM;
				end
			end
			lie_pkg::S_TERM: begin
				st_d = lie_pkg::S_ACC;
			end
			lie_pkg::S_ACC: begin
				i_d  = i_q + 1'b1;
				st_d = lie_pkg::S_BAS_INIT;
			end
			lie_pkg::S_DONE: begin
				st_d = lie_pkg::S_IDLE;
			end
			default: st_d = lie_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		idx_i    = i_q[IW-1:0];
		idx_j    = j_q[IW-1:0];
		busy     = (st_q != lie_pkg::S_IDLE);
		done     = (st_q == lie_pkg::S_DONE);
		cmd.clr  = go_eval && (st_q == lie_pkg::S_IDLE);
		unique case (st_q)
			lie_pkg::S_DUP_RD:   cmd.ld_pair = 1'b1;
			lie_pkg::S_DUP_CMP:  cmd.cmp_dup = stat.eq_x;
			lie_pkg::S_HIT_RD:   cmd.ld_pair = 1'b1;
			lie_pkg::S_HIT_CMP:  cmd.cmp_hit = stat.eq_q;
			lie_pkg::S_BAS_INIT: cmd.bas_init = 1'b1;
			lie_pkg::S_BAS_RD:   cmd.ld_pair = 1'b1;
			lie_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
			lie_pkg::S_MUL_GO:   cmd.mul_go = 1'b1;
			lie_pkg::S_MUL:      cmd.mul_basis = 1'b1;
			lie_pkg::S_TERM_GO: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = 1'b1;
			end
			lie_pkg::S_TERM:     cmd.mul_term = 1'b1;
			lie_pkg::S_ACC:      cmd.acc_add = 1'b1;
			default: ;
		endcase
		if (st_q == lie_pkg::S_BAS_INIT && i_q >= n_q) begin
			cmd.finish = 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == lie_pkg::S_MUL_GO |-> $past(stat.div_done))
		else $error("multiply without quotient");
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lie_pkg::S_MUL || st_q == lie_pkg::S_TERM) |-> $past(stat.mul_done))
		else $error("product used before ready");
	a_idle_go: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lie_pkg::S_IDLE && go_eval) |=> st_q == lie_pkg::S_DUP_RD)
		else $error("evaluate not started");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("double result");
`endif

endmodule

[rtl/lagrange_interpolation_eval_unit.sv]
// channel | signals                         | handshake
// in      | start, busy, in_word            | taken when start && !busy
// out     | result_valid, result            | one-cycle strobe, no stall
// cfg     | cfg_we, cfg_data                | written when cfg_we
// An evaluate scans node pairs for duplicates and nodes for a query match, then per ordered
// node pair runs one serial divide of a (34+FRAC_BITS)-bit numerator and a serial multiply.
// Reset clears the controller and sets node_count to 1; node stores hold
// garbage until loaded. busy stays high for the whole evaluation.
module lagrange_interpolation_eval_unit #(
	parameter int unsigned MAX_NODES = 16,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lie_pkg::in_word_t  in_word,
	output logic               result_valid,
	output lie_pkg::out_word_t result,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data
);
	localparam int unsigned IW = $clog2(MAX_NODES);

	logic [4:0]         cnt_q;
	logic               acc_in, ld_we, go_eval, done, valid_q;
	lie_pkg::dp_cmd_t   cmd;
	lie_pkg::dp_stat_t  stat;
	logic [IW-1:0]      idx_i, idx_j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 5'd1;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_data;
			end
			valid_q <= done;
		end
	end

	assign acc_in  = start && !busy;
	assign ld_we   = acc_in && (in_word.kind == lie_pkg::KIND_LOAD)
		&& (32'(in_word.node_index) < MAX_NODES);
	assign go_eval = acc_in && (in_word.kind == lie_pkg::KIND_EVAL);

	lie_ctrl #(.MAX_NODES(MAX_NODES), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .go_eval(go_eval), .node_count(cnt_q),
		.stat(stat), .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j),
		.busy(busy), .done(done)
	);

	lie_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS), .IW(IW)) u_dp (
		.clk(clk), .arst_n(arst_n), .ld_we(ld_we),
		.ld_idx(IW'(in_word.node_index)), .ld_x(in_word.node_x),
		.ld_y(in_word.node_y), .query_x(in_word.query_x),
		.idx_i(idx_i), .idx_j(idx_j), .cmd(cmd), .stat(stat), .res(result)
	);

	assign result_valid = valid_q;

endmodule
